// ----- design/jesc_pkg.sv -----
package jesc_pkg;

  localparam int PixW   = 10;
  localparam int CountW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] REG_C_REAL   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_C_IMAG   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REAL_MIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IMAG_MIN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STEP_RE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STEP_IM  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MAX_ITER = 3'd6;

  localparam logic [CountW-1:0] MaxIterReset = 16'd256;

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_MAP_R = 3'd1;
  localparam logic [2:0] OP_MAP_I = 3'd2;
  localparam logic [2:0] OP_MAP_Z = 3'd3;
  localparam logic [2:0] OP_SQR   = 3'd4;
  localparam logic [2:0] OP_SQI   = 3'd5;
  localparam logic [2:0] OP_CRS   = 3'd6;
  localparam logic [2:0] OP_UPD   = 3'd7;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic signed [31:0] real_min;
    logic signed [31:0] imag_min;
    logic [30:0]        step_real;
    logic [30:0]        step_imag;
    logic [CountW-1:0]  max_iterations;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic [2:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic escape;
  } dp_sts_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctrl_sts_t;

endpackage

// ----- design/jesc_ifs.sv -----
interface jesc_in_if;
  logic                       valid;
  logic                       ready;
  logic [jesc_pkg::PixW-1:0]  pixel_x;
  logic [jesc_pkg::PixW-1:0]  pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface jesc_out_if;
  logic                        valid;
  logic                        ready;
  logic [jesc_pkg::PixW-1:0]   out_x;
  logic [jesc_pkg::PixW-1:0]   out_y;
  logic [jesc_pkg::CountW-1:0] escape_count;
  modport source (output valid, out_x, out_y, escape_count, input ready);
  modport sink   (input valid, out_x, out_y, escape_count, output ready);
endinterface

interface jesc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [jesc_pkg::CfgIdxW-1:0]  index;
  logic [jesc_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/jesc_cfg.sv -----
module jesc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we,
  input  logic [jesc_pkg::CfgIdxW-1:0]  index,
  input  logic [jesc_pkg::CfgDataW-1:0] data,
  output jesc_pkg::cfg_t                cfg
);
  import jesc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      unique case (index)
        REG_C_REAL:   cfg_nxt.c_real         = $signed(data);
        REG_C_IMAG:   cfg_nxt.c_imag         = $signed(data);
        REG_REAL_MIN: cfg_nxt.real_min       = $signed(data);
        REG_IMAG_MIN: cfg_nxt.imag_min       = $signed(data);
        REG_STEP_RE:  cfg_nxt.step_real      = data[30:0];
        REG_STEP_IM:  cfg_nxt.step_imag      = data[30:0];
        REG_MAX_ITER: cfg_nxt.max_iterations = data[CountW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{c_real: '0, c_imag: '0, real_min: '0, imag_min: '0,
                 step_real: '0, step_imag: '0, max_iterations: MaxIterReset};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/jesc_dp.sv -----
module jesc_dp #(
  parameter int FRAC_BITS = 28
) (
  input  logic                      clk,
  input  jesc_pkg::cfg_t            cfg,
  input  jesc_pkg::dp_cmd_t         cmd,
  input  logic [jesc_pkg::PixW-1:0] in_x,
  input  logic [jesc_pkg::PixW-1:0] in_y,
  output jesc_pkg::dp_sts_t         sts,
  output logic [jesc_pkg::PixW-1:0] px,
  output logic [jesc_pkg::PixW-1:0] py
);
  import jesc_pkg::*;

  localparam bit CanEscape = (2 * FRAC_BITS + 2) <= 63;
  localparam logic [63:0] EscLimit = CanEscape ? (64'd4 << (2 * FRAC_BITS)) : 64'd0;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > $signed(65'h0_0000_0000_7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < $signed(65'h1_FFFF_FFFF_8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic [PixW-1:0]    px_r, px_nxt, py_r, py_nxt;
  logic signed [31:0] zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [63:0] p_r, p_nxt;
  logic signed [63:0] sqr_r, sqr_nxt;
  logic signed [63:0] diff_r, diff_nxt;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] re_sh, im_sh;
  logic signed [64:0] map_r_sum, map_i_sum, re_sum, im_sum;
  logic [64:0]        mag;

  // one shared 32x32 signed multiplier
  always_comb begin
    unique case (cmd.op)
      OP_MAP_R: begin
        mul_a = $signed({1'b0, cfg.step_real});
        mul_b = $signed({{(32 - PixW){1'b0}}, px_r});
      end
      OP_MAP_I: begin
        mul_a = $signed({1'b0, cfg.step_imag});
        mul_b = $signed({{(32 - PixW){1'b0}}, py_r});
      end
      OP_SQR: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
      OP_SQI: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      OP_CRS: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
    endcase
  end

  assign map_r_sum = $signed({{33{cfg.real_min[31]}}, cfg.real_min}) + $signed({p_r[63], p_r});
  assign map_i_sum = $signed({{33{cfg.imag_min[31]}}, cfg.imag_min}) + $signed({p_r[63], p_r});

  // arithmetic shift gives floor division
  assign re_sh  = diff_r >>> FRAC_BITS;
  assign im_sh  = p_r >>> (FRAC_BITS - 1);
  assign re_sum = $signed({re_sh[63], re_sh}) + $signed({{33{cfg.c_real[31]}}, cfg.c_real});
  assign im_sum = $signed({im_sh[63], im_sh}) + $signed({{33{cfg.c_imag[31]}}, cfg.c_imag});

  // in OP_CRS sqr_r holds zr^2 and p_r holds zi^2, both non-negative
  assign mag = {1'b0, sqr_r} + {1'b0, p_r};
  assign sts.escape = CanEscape && (mag > {1'b0, EscLimit});

  always_comb begin
    px_nxt   = px_r;
    py_nxt   = py_r;
    zr_nxt   = zr_r;
    zi_nxt   = zi_r;
    sqr_nxt  = sqr_r;
    diff_nxt = diff_r;
    p_nxt    = mul_a * mul_b;
    if (cmd.load) begin
      px_nxt = in_x;
      py_nxt = in_y;
    end
    unique case (cmd.op)
      OP_MAP_I: zr_nxt = sat32(map_r_sum);
      OP_MAP_Z: zi_nxt = sat32(map_i_sum);
      OP_SQI:   sqr_nxt = p_r;
      OP_CRS:   diff_nxt = sqr_r - p_r;
      OP_UPD: begin
        zr_nxt = sat32(re_sum);
        zi_nxt = sat32(im_sum);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    zr_r   <= zr_nxt;
    zi_r   <= zi_nxt;
    p_r    <= p_nxt;
    sqr_r  <= sqr_nxt;
    diff_r <= diff_nxt;
  end

  assign px = px_r;
  assign py = py_r;

endmodule

// ----- design/jesc_ctrl.sv -----
module jesc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        out_free,
  input  logic [jesc_pkg::CountW-1:0] max_iterations,
  input  jesc_pkg::dp_sts_t           dsts,
  output jesc_pkg::dp_cmd_t           cmd,
  output jesc_pkg::ctrl_sts_t         csts,
  output logic [jesc_pkg::CountW-1:0] count
);
  import jesc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAP_R = 4'd1;
  localparam logic [3:0] S_MAP_I = 4'd2;
  localparam logic [3:0] S_MAP_Z = 4'd3;
  localparam logic [3:0] S_SQR   = 4'd4;
  localparam logic [3:0] S_SQI   = 4'd5;
  localparam logic [3:0] S_CRS   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              first_r, first_nxt;
  logic [CountW-1:0] count_inc;

  assign count_inc = count_r + 16'd1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    first_nxt = first_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          count_nxt = '0;
          first_nxt = 1'b1;
          state_nxt = (max_iterations == '0) ? S_DONE : S_MAP_R;
        end
      end
      S_MAP_R: begin
        cmd.op    = OP_MAP_R;
        state_nxt = S_MAP_I;
      end
      S_MAP_I: begin
        cmd.op    = OP_MAP_I;
        state_nxt = S_MAP_Z;
      end
      S_MAP_Z: begin
        cmd.op    = OP_MAP_Z;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.op    = OP_SQR;
        state_nxt = S_SQI;
      end
      S_SQI: begin
        cmd.op    = OP_SQI;
        state_nxt = S_CRS;
      end
      S_CRS: begin
        // escape test of the previous step; the start point is never tested
        cmd.op    = OP_CRS;
        first_nxt = 1'b0;
        state_nxt = S_UPD;
        if (!first_r) begin
          if (dsts.escape) begin
            state_nxt = S_DONE;
          end else begin
            count_nxt = count_inc;
            if (count_inc == max_iterations) state_nxt = S_DONE;
          end
        end
      end
      S_UPD: begin
        cmd.op    = OP_UPD;
        state_nxt = S_SQR;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      first_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      first_r <= first_nxt;
    end
  end

  assign csts.idle = (state_r == S_IDLE);
  assign csts.done = (state_r == S_DONE);
  assign count     = count_r;

endmodule

// ----- design/julia_escape_time_pixel_unit.sv -----
// channel  dir  handshake      payload
// in_ch    in   valid/ready    pixel_x[9:0], pixel_y[9:0]
// out_ch   out  valid/ready    out_x[9:0], out_y[9:0], escape_count[15:0]
// cfg_ch   in   valid/ready    index[2:0], data[31:0] (ready always high)
//
// One item at a time: accept, map the pixel (MAP_R, MAP_I, MAP_Z), then iterate
// SQR, SQI, CRS and UPD on the single shared 32x32 multiplier until escape or the limit;
// a zero limit goes from accept straight to done.
// Synchronous active-low reset clears control; max_iterations resets to 256.
// A finished result sits in the output register; a new item is accepted meanwhile
// and only the next finished result waits for out_ch.ready.
module julia_escape_time_pixel_unit #(
  parameter int FRAC_BITS = 28
) (
  input  logic       clk,
  input  logic       rst_n,
  jesc_in_if.sink    in_ch,
  jesc_out_if.source out_ch,
  jesc_cfg_if.sink   cfg_ch
);
  import jesc_pkg::*;

  cfg_t              cfg;
  dp_cmd_t           cmd;
  dp_sts_t           dsts;
  ctrl_sts_t         csts;
  logic [CountW-1:0] count;
  logic [PixW-1:0]   px, py;
  logic              out_free, res_load;

  logic              out_valid_r, out_valid_nxt;
  logic [PixW-1:0]   out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [CountW-1:0] out_cnt_r, out_cnt_nxt;

  assign cfg_ch.ready = 1'b1;

  jesc_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_ch.valid),
    .index (cfg_ch.index),
    .data  (cfg_ch.data),
    .cfg   (cfg)
  );

  jesc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .out_free       (out_free),
    .max_iterations (cfg.max_iterations),
    .dsts           (dsts),
    .cmd            (cmd),
    .csts           (csts),
    .count          (count)
  );

  jesc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk  (clk),
    .cfg  (cfg),
    .cmd  (cmd),
    .in_x (in_ch.pixel_x),
    .in_y (in_ch.pixel_y),
    .sts  (dsts),
    .px   (px),
    .py   (py)
  );

  assign in_ch.ready = csts.idle;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign res_load    = csts.done && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_cnt_nxt   = out_cnt_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = px;
      out_y_nxt     = py;
      out_cnt_nxt   = count;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_x        = out_x_r;
  assign out_ch.out_y        = out_y_r;
  assign out_ch.escape_count = out_cnt_r;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still ready after an item was taken");

  a_zero_limit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && cfg.max_iterations == '0) |=> csts.done)
    else $error("zero iteration limit did not finish at once");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(csts.done))
    else $error("result appeared without a finished item");
`endif

endmodule

// ----- tb/julia_escape_time_pixel_unit_test.sv -----
module julia_escape_time_pixel_unit_test;
  import jesc_pkg::*;

  localparam int FracBits = 28;
  localparam int QuietLimit = 1_000_000;
  localparam int RandomItems = 1525;
  localparam logic [63:0] EscapeLimit = 64'd4 << (2 * FracBits);
  // index past the end of the register list; the block must ignore it
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  localparam logic [31:0] QTwo      = 32'h2000_0000;
  localparam logic [31:0] QMinusTwo = 32'hE000_0000;
  localparam logic [31:0] QOne      = 32'h1000_0000;

  typedef struct packed {
    logic [PixW-1:0] x;
    logic [PixW-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0]   x;
    logic [PixW-1:0]   y;
    logic [CountW-1:0] count;
  } escape_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #10 clk = ~clk;

  // testbench-side drive variables, known from time zero
  logic                px_valid = 1'b0;
  logic [PixW-1:0]     px_x = '0;
  logic [PixW-1:0]     px_y = '0;
  logic                res_ready = 1'b1;
  logic                wr_valid = 1'b0;
  logic [CfgIdxW-1:0]  wr_index = '0;
  logic [CfgDataW-1:0] wr_data = '0;

  jesc_in_if  in_ch ();
  jesc_out_if out_ch ();
  jesc_cfg_if cfg_ch ();

  assign in_ch.valid   = px_valid;
  assign in_ch.pixel_x = px_x;
  assign in_ch.pixel_y = px_y;
  assign out_ch.ready  = res_ready;
  assign cfg_ch.valid  = wr_valid;
  assign cfg_ch.index  = wr_index;
  assign cfg_ch.data   = wr_data;

  julia_escape_time_pixel_unit #(.FRAC_BITS(FracBits)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // register copies as the block should hold them
  logic signed [31:0] c_re = '0;
  logic signed [31:0] c_im = '0;
  logic signed [31:0] org_re = '0;
  logic signed [31:0] org_im = '0;
  logic [30:0]        inc_re = '0;
  logic [30:0]        inc_im = '0;
  logic [CountW-1:0]  iter_cap = MaxIterReset;

  pixel_t         pixels_to_send[$];
  escape_result_t escape_results[$];
  int             results_owed = 0;
  int             errors = 0;
  int             quiet = 0;
  int             in_gap = 0;
  int             out_gap = 0;
  bit             idle_on = 1'b0;
  bit             in_taken = 1'b0;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [CountW-1:0] escape_steps(input logic [PixW-1:0] x,
                                                     input logic [PixW-1:0] y);
    longint      zr, zi, cr, ci, sq_re, sq_im, next_im;
    logic [63:0] mag;
    int unsigned n;
    bit          gone;
    cr = longint'(c_re);
    ci = longint'(c_im);
    zr = clamp32(longint'(org_re) + longint'(inc_re) * longint'(x));
    zi = clamp32(longint'(org_im) + longint'(inc_im) * longint'(y));
    n = 0;
    gone = 1'b0;
    while (n < iter_cap && !gone) begin
      sq_re = zr * zr;
      sq_im = zi * zi;
      next_im = clamp32(((zr * zi) >>> (FracBits - 1)) + ci);
      zr = clamp32(((sq_re - sq_im) >>> FracBits) + cr);
      zi = next_im;
      // exact magnitude; the sum can reach 2^63, so compare unsigned
      mag = $unsigned(zr * zr) + $unsigned(zi * zi);
      if (mag > EscapeLimit) gone = 1'b1;
      else n++;
    end
    return n[CountW-1:0];
  endfunction

  // monitor and checker
  always @(posedge clk) begin
    escape_result_t want;
    in_taken = in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_C_REAL:   c_re = cfg_ch.data;
          REG_C_IMAG:   c_im = cfg_ch.data;
          REG_REAL_MIN: org_re = cfg_ch.data;
          REG_IMAG_MIN: org_im = cfg_ch.data;
          REG_STEP_RE:  inc_re = cfg_ch.data[30:0];
          REG_STEP_IM:  inc_im = cfg_ch.data[30:0];
          REG_MAX_ITER: iter_cap = cfg_ch.data[CountW-1:0];
          default: ;
        endcase
      end
      if (in_taken) begin
        want.x = in_ch.pixel_x;
        want.y = in_ch.pixel_y;
        want.count = escape_steps(in_ch.pixel_x, in_ch.pixel_y);
        escape_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (escape_results.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d count=%0d", $time,
                   out_ch.out_x, out_ch.out_y, out_ch.escape_count);
          errors++;
        end else begin
          want = escape_results.pop_front();
          results_owed--;
          if (out_ch.out_x !== want.x || out_ch.out_y !== want.y ||
              out_ch.escape_count !== want.count) begin
            $display("%0t: mismatch expected x=%0d y=%0d count=%0d, got x=%0d y=%0d count=%0d",
                     $time, want.x, want.y, want.count,
                     out_ch.out_x, out_ch.out_y, out_ch.escape_count);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet);
      $display("Verification failed");
      $finish;
    end
  end

  // pixel driver and result-side stalls
  always @(negedge clk) begin
    pixel_t cur;
    if (!rst_n) begin
      px_valid <= 1'b0;
    end else if (px_valid && !in_taken) begin
      // hold the item until it is taken
    end else if (in_gap != 0) begin
      in_gap--;
      px_valid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      in_gap = $urandom_range(0, 18);
      px_valid <= 1'b0;
    end else if (pixels_to_send.size() != 0) begin
      cur = pixels_to_send.pop_front();
      results_owed++;
      px_valid <= 1'b1;
      px_x <= cur.x;
      px_y <= cur.y;
    end else begin
      px_valid <= 1'b0;
    end

    if (out_gap != 0) begin
      out_gap--;
      res_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 18);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  task automatic queue_pixel(input int x, input int y);
    pixel_t p;
    p.x = x[PixW-1:0];
    p.y = y[PixW-1:0];
    pixels_to_send.push_back(p);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    wr_valid <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] cr, input logic [31:0] ci,
                           input logic [31:0] rmin, input logic [31:0] imin,
                           input logic [31:0] sre, input logic [31:0] sim,
                           input logic [31:0] cap);
    write_reg(REG_C_REAL, cr);
    write_reg(REG_C_IMAG, ci);
    write_reg(REG_REAL_MIN, rmin);
    write_reg(REG_IMAG_MIN, imin);
    write_reg(REG_STEP_RE, sre);
    write_reg(REG_STEP_IM, sim);
    write_reg(REG_MAX_ITER, cap);
    @(negedge clk);
    wr_valid <= 1'b0;
  endtask

  // sender holds off until every result is back, then a short settle
  task automatic wait_drained();
    while (pixels_to_send.size() != 0 || results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    int sent, n, kind, w, h, i;
    logic [31:0] cr, ci, rmin, imin, sre, sim, cap;
    bit last;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: z and c are zero, so the point stays put until the cap
    idle_on = 1'b1;
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    wait_drained();

    // full-plane window; ignored index, masked step and cap bits
    write_reg(RegUnused, 32'hFFFF_FFFF);
    load_regs('0, '0, QMinusTwo, QMinusTwo, 32'h8010_0000, 32'h0010_0000, 32'hABCD_0020);
    queue_pixel(0, 0);
    queue_pixel(512, 512);
    queue_pixel(512, 0);
    queue_pixel(0, 512);
    queue_pixel(1023, 1023);
    queue_pixel(1023, 0);
    queue_pixel(0, 1023);
    queue_pixel(700, 300);
    queue_pixel(341, 682);
    wait_drained();

    // c = -2: the orbit sits at magnitude exactly 2 and must not escape
    load_regs(QMinusTwo, '0, '0, '0, '0, '0, 32'd40);
    queue_pixel(5, 9);
    wait_drained();
    load_regs(QMinusTwo, '0, QTwo, '0, '0, '0, 32'd40);
    queue_pixel(3, 0);
    wait_drained();

    // saturation of the start point and of the first step, largest cap
    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF);
    queue_pixel(1023, 1023);
    queue_pixel(0, 0);
    queue_pixel(1023, 0);
    wait_drained();

    // one bounded point at the largest cap
    load_regs('0, '0, '0, '0, '0, '0, 32'h0000_FFFF);
    queue_pixel(1, 2);
    wait_drained();

    // zero cap: no iteration at all
    load_regs(QOne, QOne, QMinusTwo, QMinusTwo, 32'h0010_0000, 32'h0010_0000, 32'd0);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(17, 900);
    wait_drained();

    // single step
    write_reg(REG_MAX_ITER, 32'd1);
    @(negedge clk);
    wr_valid <= 1'b0;
    queue_pixel(256, 256);
    queue_pixel(600, 100);
    wait_drained();

    sent = 0;
    while (sent < RandomItems) begin
      kind = $urandom_range(0, 9);
      w = $urandom_range(1, 1024);
      h = $urandom_range(1, 1024);
      cr = 32'($urandom_range(0, 32'h2000_0000)) - QOne;
      ci = 32'($urandom_range(0, 32'h2000_0000)) - QOne;
      rmin = QMinusTwo + $urandom_range(0, 32'h0200_0000);
      imin = QMinusTwo + $urandom_range(0, 32'h0200_0000);
      sre = 32'h4000_0000 / w;
      sim = 32'h4000_0000 / h;
      cap = {16'($urandom), 16'($urandom_range(1, 48))};
      if (kind == 6) begin
        cap = $urandom_range(100, 400);
      end else if (kind == 7 || kind == 8) begin
        // c, origin and step bits all random; such points mostly leave at once
        cr = $urandom;
        ci = $urandom;
        rmin = $urandom;
        imin = $urandom;
        sre = $urandom;
        sim = $urandom;
        cap = {16'($urandom), 16'($urandom_range(1, 64))};
        w = 1024;
        h = 1024;
      end else if (kind == 9) begin
        cr = 32'hF333_3333;
        ci = 32'h027E_F9DB;
        cap = $urandom_range(1, 64);
      end
      n = (kind == 6) ? $urandom_range(20, 40) : $urandom_range(60, 160);
      last = (sent + n >= RandomItems);
      idle_on = last ? 1'b0 : ($urandom_range(0, 3) != 0);
      load_regs(cr, ci, rmin, imin, sre, sim, cap);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 7)
          queue_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
        else
          queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      sent += n;
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (escape_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, escape_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
